// ===== hw/rtl/frame_admission_rate_limiter_assert.svh =====
// assertion macros for the frame admission rate limiter
// used by the top level only; expects clk and arst_n in scope
`ifndef FRAME_ADMISSION_RATE_LIMITER_ASSERT_SVH
`define FRAME_ADMISSION_RATE_LIMITER_ASSERT_SVH

// condition implies consequence in the same cycle
`define FRL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define FRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/frl_pkg.sv =====
// shared types and constants of the frame admission rate limiter
// no dependencies; used by frl_ser_mul, frl_ser_div and the top level
package frl_pkg;

	// field and datapath widths
	localparam int TIME_W    = 48;
	localparam int DOWN_W    = 24;
	localparam int CNT_W     = 32;
	localparam int EWMA_W    = 32;
	localparam int RATE_W    = 16;
	localparam int ACC_W     = 48;
	localparam int MUL_A_W   = 32;
	localparam int DIV_W     = 28;
	localparam int STREAK_W  = 8;
	localparam int STEP_W    = 3;
	localparam int VERDICT_W = 3;
	localparam int CFG_IDX_W = 2;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_FORWARDED   = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_HELD        = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_SKIPPED     = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_NO_LISTENER = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_NOBUF       = 3'd4;
	localparam logic [VERDICT_W-1:0] VERDICT_BACKOFF     = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INFER_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INFER_CFG    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INFER_SW     = 2'd3;

	// configuration reset values
	localparam logic [RATE_W-1:0] CAPTURE_RATE_RST = 16'd7680;

	// dividends: microseconds and milliseconds per frame at Q8.8 rate
	localparam logic [DIV_W-1:0] INTERVAL_NUM = 28'd256000000;
	localparam logic [DIV_W-1:0] BASE_NUM     = 28'd256000;
	localparam logic [RATE_W-1:0] US_PER_MS   = 16'd1000;
	localparam int Q8_ONE                     = 256;

	// load ratio limits of ewma_q8 * fps, one unit is 65536 * 1e6
	localparam logic [ACC_W-1:0] LOAD_HI  = 48'(64'd2 * 64'd65536 * 64'd1000000);
	localparam logic [ACC_W-1:0] LOAD_MID = 48'((64'd13 * 64'd65536 * 64'd1000000) / 64'd10);

	// multiplier command
	typedef struct packed {
		logic               start;
		logic               keep;
		logic [MUL_A_W-1:0] a;
		logic [RATE_W-1:0]  b;
	} mul_cmd_t;

	// divider command
	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [RATE_W-1:0] divisor;
	} div_cmd_t;

endpackage

// ===== hw/rtl/frl_ser_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle, with optional accumulate
// depends on frl_pkg
module frl_ser_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frl_pkg::mul_cmd_t          cmd,
	output logic                       busy,
	output logic [frl_pkg::ACC_W-1:0]  prod
);

	logic [frl_pkg::RATE_W-1:0] b_q;
	logic [frl_pkg::ACC_W-1:0]  a_q;
	logic [frl_pkg::ACC_W-1:0]  acc_q;

	assign busy = (b_q != '0);
	assign prod = acc_q;

	// multiplier bits shift out, runs until none are left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (cmd.start) begin
			b_q <= cmd.b;
		end else if (busy) begin
			b_q <= b_q >> 1;
		end
	end

	// multiplicand shifts up, partial product added on a set bit
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= frl_pkg::ACC_W'(cmd.a);
			if (!cmd.keep) begin
				acc_q <= '0;
			end
		end else if (busy) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[frl_pkg::ACC_W-2:0], 1'b0};
		end
	end

endmodule

// ===== hw/rtl/frl_ser_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on frl_pkg
module frl_ser_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frl_pkg::div_cmd_t          cmd,
	output logic                       busy,
	output logic [frl_pkg::DIV_W-1:0]  quot
);

	localparam int CNT_BITS = $clog2(frl_pkg::DIV_W + 1);

	logic [CNT_BITS-1:0]         cnt_q;
	logic [frl_pkg::DIV_W-1:0]   q_q;
	logic [frl_pkg::RATE_W-1:0]  rem_q;
	logic [frl_pkg::RATE_W-1:0]  dvsr_q;
	logic [frl_pkg::RATE_W:0]    trial;
	logic [frl_pkg::RATE_W:0]    diff;
	logic                        fits;

	assign busy = (cnt_q != '0);
	assign quot = q_q;

	// next partial remainder
	assign trial = {rem_q, q_q[frl_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign fits  = (trial >= {1'b0, dvsr_q});

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= CNT_BITS'(frl_pkg::DIV_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// dividend bits shift out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q    <= cmd.dividend;
			rem_q  <= '0;
			dvsr_q <= cmd.divisor;
		end else if (busy) begin
			q_q   <= {q_q[frl_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? diff[frl_pkg::RATE_W-1:0] : trial[frl_pkg::RATE_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/frame_admission_rate_limiter.sv =====
// Frame admission rate limiter. Each input word is one camera event (frame read
// or failed read) and yields exactly one result word. A skipped frame or a frame
// with no listeners needs no arithmetic and goes straight to its result; a
// forwarded or held frame waits for the 28-step divider computing the frame
// interval; a failed read waits for the serial multiply over the bits of the
// effective rate, and when it triggers backoff also for the 28-step divider, then
// a 10-bit serial multiply to microseconds. One word is worked on at a time; a
// new word is taken while the previous result still waits in the output register.
// Configuration writes are meant for idle periods only.
// depends on frl_pkg, frl_ser_mul, frl_ser_div, frame_admission_rate_limiter_assert.svh
module frame_admission_rate_limiter #(
	parameter int EMA_WEIGHT_Q8    = 77,
	parameter int SAFETY_Q8        = 307,
	parameter int MAX_BACKOFF_STEP = 4,
	parameter int BACKOFF_CAP_MS   = 1000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [frl_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [frl_pkg::RATE_W-1:0]      cfg_data,
	// event channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [frl_pkg::TIME_W-1:0]      now_us,
	input  logic [frl_pkg::DOWN_W-1:0]      downstream_max_us,
	input  logic                            has_listeners,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [frl_pkg::VERDICT_W-1:0]   verdict,
	output logic [frl_pkg::CNT_W-1:0]       frame_number,
	output logic [frl_pkg::CNT_W-1:0]       delivered_count,
	output logic [frl_pkg::CNT_W-1:0]       skipped_count,
	output logic [frl_pkg::CNT_W-1:0]       starved_count,
	output logic [frl_pkg::DOWN_W-1:0]      smoothed_proc_us,
	output logic [frl_pkg::TIME_W-1:0]      admit_after_us
);

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_EVAL   = 4'd1;
	localparam logic [3:0] ST_EW_B   = 4'd2;
	localparam logic [3:0] ST_EW_SUM = 4'd3;
	localparam logic [3:0] ST_SAFE   = 4'd4;
	localparam logic [3:0] ST_SAFE_W = 4'd5;
	localparam logic [3:0] ST_STREAK = 4'd6;
	localparam logic [3:0] ST_BASE   = 4'd7;
	localparam logic [3:0] ST_BOFF_W = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	localparam logic [frl_pkg::STEP_W-1:0] STEP_MAX = frl_pkg::STEP_W'(MAX_BACKOFF_STEP);
	localparam logic [frl_pkg::RATE_W-1:0] W_NEW    = frl_pkg::RATE_W'(EMA_WEIGHT_Q8);
	localparam logic [frl_pkg::RATE_W-1:0] W_OLD    =
		frl_pkg::RATE_W'(frl_pkg::Q8_ONE - EMA_WEIGHT_Q8);
	localparam logic [frl_pkg::RATE_W-1:0] SAFETY   = frl_pkg::RATE_W'(SAFETY_Q8);
	localparam logic [24:0]                CAP_WIDE = 25'(BACKOFF_CAP_MS);
	localparam logic [frl_pkg::RATE_W-1:0] CAP_MS   = frl_pkg::RATE_W'(BACKOFF_CAP_MS);

	// configuration registers
	logic [frl_pkg::RATE_W-1:0] cap_rate_q;
	logic [frl_pkg::RATE_W-1:0] lim_rate_q;
	logic                       infer_cfg_q;
	logic                       infer_sw_q;

	// block state
	logic [3:0]                     state_q;
	logic [frl_pkg::EWMA_W-1:0]     ewma_q;
	logic [frl_pkg::TIME_W-1:0]     admit_q;
	logic [frl_pkg::STREAK_W-1:0]   fail_streak_q;
	logic [frl_pkg::STEP_W-1:0]     backoff_step_q;
	logic [frl_pkg::CNT_W-1:0]      next_num_q;
	logic [frl_pkg::CNT_W-1:0]      delivered_q;
	logic [frl_pkg::CNT_W-1:0]      skipped_q;
	logic [frl_pkg::CNT_W-1:0]      starved_q;
	logic [frl_pkg::VERDICT_W-1:0]  res_verdict_q;
	logic [frl_pkg::CNT_W-1:0]      res_number_q;
	logic                           out_valid_q;

	// captured word
	logic                           act_q;
	logic [frl_pkg::TIME_W-1:0]     now_q;
	logic [frl_pkg::DOWN_W-1:0]     down_q;
	logic                           listen_q;
	logic [frl_pkg::RATE_W-1:0]     fps_q;

	// output register
	logic [frl_pkg::VERDICT_W-1:0]  o_verdict_q;
	logic [frl_pkg::CNT_W-1:0]      o_number_q;
	logic [frl_pkg::CNT_W-1:0]      o_delivered_q;
	logic [frl_pkg::CNT_W-1:0]      o_skipped_q;
	logic [frl_pkg::CNT_W-1:0]      o_starved_q;
	logic [frl_pkg::DOWN_W-1:0]     o_smoothed_q;
	logic [frl_pkg::TIME_W-1:0]     o_admit_q;

	// datapath
	logic [frl_pkg::RATE_W-1:0]     fps_eff;
	frl_pkg::mul_cmd_t              mul_cmd;
	frl_pkg::div_cmd_t              div_cmd;
	logic                           mul_busy;
	logic                           div_busy;
	logic [frl_pkg::ACC_W-1:0]      prod;
	logic [frl_pkg::DIV_W-1:0]      quot;
	logic                           early_out;
	logic [39:0]                    ewma_sum;
	logic [frl_pkg::EWMA_W-1:0]     ewma_sat;
	logic [frl_pkg::DIV_W-1:0]      safe_us;
	logic [frl_pkg::DIV_W-1:0]      hold_us;
	logic [frl_pkg::TIME_W-1:0]     delta_us;
	logic [frl_pkg::TIME_W:0]       admit_sum;
	logic [frl_pkg::TIME_W-1:0]     admit_sat;
	logic [1:0]                     streak_thr;
	logic [24:0]                    cool_wide;
	logic [frl_pkg::RATE_W-1:0]     cool_ms;
	logic                           in_take;
	logic                           out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// effective rate: inference cap when set and lower, never zero
	always_comb begin
		fps_eff = cap_rate_q;
		if (lim_rate_q != '0 && lim_rate_q < fps_eff) begin
			fps_eff = lim_rate_q;
		end
		if (fps_eff == '0) begin
			fps_eff = frl_pkg::RATE_W'(1);
		end
	end

	// frame outside the window or nobody listening needs no arithmetic
	assign early_out = (now_q < admit_q) || !listen_q;

	// ewma fold, saturated to 32 bits
	assign ewma_sum = prod[47:8];
	assign ewma_sat = (ewma_sum[39:32] != '0) ? '1 : ewma_sum[31:0];

	// hold time is the larger of safety term and frame interval
	assign safe_us = {2'b00, prod[41:16]};
	assign hold_us = (safe_us > quot) ? safe_us : quot;

	// admission time add, shared by both update paths
	assign delta_us  = (state_q == ST_SAFE_W) ? frl_pkg::TIME_W'(hold_us)
	                                          : frl_pkg::TIME_W'(prod[25:0]);
	assign admit_sum = {1'b0, now_q} + {1'b0, delta_us};
	assign admit_sat = admit_sum[frl_pkg::TIME_W] ? '1 : admit_sum[frl_pkg::TIME_W-1:0];

	// streak threshold from the load ratio
	always_comb begin
		if (prod >= frl_pkg::LOAD_HI) begin
			streak_thr = 2'd1;
		end else if (prod >= frl_pkg::LOAD_MID) begin
			streak_thr = 2'd2;
		end else begin
			streak_thr = 2'd3;
		end
	end

	// backoff cooldown in ms, capped
	assign cool_wide = 25'(quot[17:0]) << backoff_step_q;
	assign cool_ms   = (cool_wide > CAP_WIDE) ? CAP_MS : cool_wide[frl_pkg::RATE_W-1:0];

	// commands to the serial units
	always_comb begin
		mul_cmd = '0;
		div_cmd = '0;
		div_cmd.divisor = fps_q;
		case (state_q)
			ST_EVAL: begin
				if (act_q) begin
					mul_cmd.start    = 1'b1;
					mul_cmd.a        = ewma_q;
					mul_cmd.b        = fps_q;
					div_cmd.start    = 1'b1;
					div_cmd.dividend = frl_pkg::BASE_NUM;
				end else if (!early_out) begin
					div_cmd.start    = 1'b1;
					div_cmd.dividend = frl_pkg::INTERVAL_NUM;
					if (down_q != '0) begin
						mul_cmd.start = 1'b1;
						mul_cmd.a     = ewma_q;
						mul_cmd.b     = W_OLD;
					end
				end
			end
			ST_EW_B: begin
				if (!mul_busy) begin
					mul_cmd.start = 1'b1;
					mul_cmd.keep  = 1'b1;
					mul_cmd.a     = {down_q, 8'h00};
					mul_cmd.b     = W_NEW;
				end
			end
			ST_SAFE: begin
				mul_cmd.start = 1'b1;
				mul_cmd.a     = ewma_q;
				mul_cmd.b     = SAFETY;
			end
			ST_BASE: begin
				if (!div_busy) begin
					mul_cmd.start = 1'b1;
					mul_cmd.a     = frl_pkg::MUL_A_W'(cool_ms);
					mul_cmd.b     = frl_pkg::US_PER_MS;
				end
			end
			default: begin
			end
		endcase
	end

	frl_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.busy   (mul_busy),
		.prod   (prod)
	);

	frl_ser_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.busy   (div_busy),
		.quot   (quot)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_rate_q  <= frl_pkg::CAPTURE_RATE_RST;
			lim_rate_q  <= '0;
			infer_cfg_q <= 1'b1;
			infer_sw_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				frl_pkg::REG_CAPTURE_RATE: cap_rate_q  <= cfg_data;
				frl_pkg::REG_INFER_LIMIT:  lim_rate_q  <= cfg_data;
				frl_pkg::REG_INFER_CFG:    infer_cfg_q <= cfg_data[0];
				frl_pkg::REG_INFER_SW:     infer_sw_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// capture the incoming word and its effective rate
	always_ff @(posedge clk) begin
		if (in_take) begin
			act_q    <= action;
			now_q    <= now_us;
			down_q   <= downstream_max_us;
			listen_q <= has_listeners;
			fps_q    <= fps_eff;
		end
	end

	// sequencer and limiter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ewma_q         <= '0;
			admit_q        <= '0;
			fail_streak_q  <= '0;
			backoff_step_q <= '0;
			next_num_q     <= '0;
			delivered_q    <= '0;
			skipped_q      <= '0;
			starved_q      <= '0;
			res_verdict_q  <= frl_pkg::VERDICT_FORWARDED;
			res_number_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					res_number_q <= '0;
					if (act_q) begin
						starved_q <= starved_q + 1'b1;
						if (fail_streak_q != '1) begin
							fail_streak_q <= fail_streak_q + 1'b1;
						end
						state_q <= ST_STREAK;
					end else begin
						fail_streak_q  <= '0;
						backoff_step_q <= '0;
						if (now_q < admit_q) begin
							skipped_q     <= skipped_q + 1'b1;
							res_verdict_q <= frl_pkg::VERDICT_SKIPPED;
							state_q       <= ST_DONE;
						end else begin
							res_number_q <= next_num_q;
							next_num_q   <= next_num_q + 1'b1;
							if (!listen_q) begin
								res_verdict_q <= frl_pkg::VERDICT_NO_LISTENER;
								state_q       <= ST_DONE;
							end else begin
								res_verdict_q <= (infer_cfg_q && infer_sw_q) ?
									frl_pkg::VERDICT_FORWARDED : frl_pkg::VERDICT_HELD;
								delivered_q   <= delivered_q + 1'b1;
								state_q       <= (down_q != '0) ? ST_EW_B : ST_SAFE;
							end
						end
					end
				end
				ST_EW_B: begin
					if (!mul_busy) begin
						state_q <= ST_EW_SUM;
					end
				end
				ST_EW_SUM: begin
					if (!mul_busy) begin
						ewma_q  <= ewma_sat;
						state_q <= ST_SAFE;
					end
				end
				ST_SAFE: begin
					state_q <= ST_SAFE_W;
				end
				ST_SAFE_W: begin
					if (!mul_busy && !div_busy) begin
						admit_q <= admit_sat;
						state_q <= ST_DONE;
					end
				end
				ST_STREAK: begin
					if (!mul_busy) begin
						if (fail_streak_q >= frl_pkg::STREAK_W'(streak_thr)) begin
							state_q <= ST_BASE;
						end else begin
							res_verdict_q <= frl_pkg::VERDICT_NOBUF;
							state_q       <= ST_DONE;
						end
					end
				end
				ST_BASE: begin
					if (!div_busy) begin
						if (backoff_step_q < STEP_MAX) begin
							backoff_step_q <= backoff_step_q + 1'b1;
						end
						state_q <= ST_BOFF_W;
					end
				end
				ST_BOFF_W: begin
					if (!mul_busy) begin
						admit_q       <= admit_sat;
						res_verdict_q <= frl_pkg::VERDICT_BACKOFF;
						state_q       <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload, a snapshot so the next word can update state
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_verdict_q   <= res_verdict_q;
			o_number_q    <= res_number_q;
			o_delivered_q <= delivered_q;
			o_skipped_q   <= skipped_q;
			o_starved_q   <= starved_q;
			o_smoothed_q  <= ewma_q[31:8];
			o_admit_q     <= admit_q;
		end
	end

	assign verdict          = o_verdict_q;
	assign frame_number     = o_number_q;
	assign delivered_count  = o_delivered_q;
	assign skipped_count    = o_skipped_q;
	assign starved_count    = o_starved_q;
	assign smoothed_proc_us = o_smoothed_q;
	assign admit_after_us   = o_admit_q;

	// checks
	`include "frame_admission_rate_limiter_assert.svh"

	`FRL_ASSERT_SAME(a_unnumbered_verdicts, out_valid_q && (o_verdict_q == frl_pkg::VERDICT_SKIPPED || o_verdict_q == frl_pkg::VERDICT_NOBUF || o_verdict_q == frl_pkg::VERDICT_BACKOFF), o_number_q == '0, "frame number set on a verdict without a number")
	`FRL_ASSERT_NEXT(a_read_clears_streak, state_q == ST_EVAL && !act_q, fail_streak_q == '0 && backoff_step_q == '0, "successful read left streak or backoff")
	`FRL_ASSERT_SAME(a_step_bounded, state_q != ST_IDLE || state_q == ST_IDLE, backoff_step_q <= STEP_MAX || STEP_MAX == '0 && backoff_step_q == '0, "backoff step beyond its maximum")

endmodule

// ===== sim/frame_admission_rate_limiter_tb.sv =====
// self-checking testbench for frame_admission_rate_limiter: directed and random camera
// events against an in-bench admission predictor, with bursty sender and stalling receiver
// depends on frl_pkg and the frame_admission_rate_limiter rtl
`timescale 1ns / 1ps

module frame_admission_rate_limiter_tb;
	import frl_pkg::*;

	localparam int EWMA_GAIN         = 77;
	localparam int SAFETY_GAIN       = 307;
	localparam int BACKOFF_STEPS_MAX = 4;
	localparam int BACKOFF_LIMIT_MS  = 1000;

	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_NOBUF = 1'b1;

	localparam logic [TIME_W-1:0] MAX_TIME  = '1;
	localparam logic [63:0]       LOAD_UNIT = 64'd65536 * 64'd1000000;
	localparam int                STALL_LIMIT = 5000;

	typedef struct packed {
		logic              act;
		logic [TIME_W-1:0] now;
		logic [DOWN_W-1:0] down;
		logic              listen;
	} cam_event_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [CNT_W-1:0]     number;
		logic [CNT_W-1:0]     delivered;
		logic [CNT_W-1:0]     skipped;
		logic [CNT_W-1:0]     starved;
		logic [DOWN_W-1:0]    smoothed;
		logic [TIME_W-1:0]    admit;
	} admit_result_t;

	// dut ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [RATE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 action = 1'b0;
	logic [TIME_W-1:0]    now_us = '0;
	logic [DOWN_W-1:0]    downstream_max_us = '0;
	logic                 has_listeners = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [VERDICT_W-1:0] verdict;
	logic [CNT_W-1:0]     frame_number;
	logic [CNT_W-1:0]     delivered_count;
	logic [CNT_W-1:0]     skipped_count;
	logic [CNT_W-1:0]     starved_count;
	logic [DOWN_W-1:0]    smoothed_proc_us;
	logic [TIME_W-1:0]    admit_after_us;

	// predictor copy of configuration and state
	logic [RATE_W-1:0]   cap_rate = 16'd7680;
	logic [RATE_W-1:0]   rate_cap = '0;
	logic                inf_cfg = 1'b1;
	logic                inf_sw = 1'b1;
	logic [EWMA_W-1:0]   ewma = '0;
	logic [TIME_W-1:0]   admit_at = '0;
	logic [STREAK_W-1:0] streak = '0;
	logic [STEP_W-1:0]   bo_step = '0;
	logic [CNT_W-1:0]    frame_seq = '0;
	logic [CNT_W-1:0]    n_delivered = '0;
	logic [CNT_W-1:0]    n_skipped = '0;
	logic [CNT_W-1:0]    n_starved = '0;

	admit_result_t     results_due[$];
	logic [TIME_W-1:0] t_now = '0;
	bit                valid_on = 1'b0;
	int                burst_left = 1;
	int                fail_count = 0;
	int                idle_cycles = 0;

	// receiver stall pattern
	logic [1:0]  ready_mode = '0;
	logic [15:0] ready_pat = '0;
	logic [5:0]  ready_age = '0;

	frame_admission_rate_limiter #(
		.EMA_WEIGHT_Q8    (EWMA_GAIN),
		.SAFETY_Q8        (SAFETY_GAIN),
		.MAX_BACKOFF_STEP (BACKOFF_STEPS_MAX),
		.BACKOFF_CAP_MS   (BACKOFF_LIMIT_MS)
	) dut (.*);

	always #6 clk = ~clk;

	// effective rate in q8.8, zero taken as the smallest rate
	function automatic logic [63:0] pick_fps();
		logic [63:0] f;
		f = {48'd0, cap_rate};
		if (rate_cap != 0 && rate_cap < cap_rate)
			f = {48'd0, rate_cap};
		if (f == 0)
			f = 64'd1;
		return f;
	endfunction

	function automatic logic [TIME_W-1:0] clamp_time(logic [63:0] t);
		return (t > {16'd0, MAX_TIME}) ? MAX_TIME : t[TIME_W-1:0];
	endfunction

	// admission decision and state update for one accepted word
	function automatic admit_result_t judge_event(cam_event_t ev);
		admit_result_t r;
		logic [63:0]   fps;
		logic [63:0]   load;
		logic [63:0]   e;
		logic [63:0]   span;
		logic [63:0]   guard;
		logic [63:0]   cool;
		logic [1:0]    need;
		fps = pick_fps();
		r.number = '0;
		if (ev.act == ACT_NOBUF) begin
			n_starved = n_starved + 1;
			if (streak != 8'hFF)
				streak = streak + 1;
			// failed-read streak needed depends on load ratio
			load = {32'd0, ewma} * fps;
			if (load >= 64'd2 * LOAD_UNIT)
				need = 2'd1;
			else if (load * 64'd10 >= 64'd13 * LOAD_UNIT)
				need = 2'd2;
			else
				need = 2'd3;
			if (streak >= need) begin
				cool = (64'd256000 / fps) << bo_step;
				if (cool > BACKOFF_LIMIT_MS)
					cool = BACKOFF_LIMIT_MS;
				admit_at = clamp_time({16'd0, ev.now} + cool * 64'd1000);
				if (bo_step < BACKOFF_STEPS_MAX)
					bo_step = bo_step + 1;
				r.verdict = VERDICT_BACKOFF;
			end else begin
				r.verdict = VERDICT_NOBUF;
			end
		end else begin
			streak = '0;
			bo_step = '0;
			if (ev.now < admit_at) begin
				n_skipped = n_skipped + 1;
				r.verdict = VERDICT_SKIPPED;
			end else begin
				r.number = frame_seq;
				frame_seq = frame_seq + 1;
				if (!ev.listen) begin
					r.verdict = VERDICT_NO_LISTENER;
				end else begin
					r.verdict = (inf_cfg && inf_sw) ? VERDICT_FORWARDED : VERDICT_HELD;
					// smooth downstream time, then pick the larger spacing
					if (ev.down != 0) begin
						e = (EWMA_GAIN * ({40'd0, ev.down} << 8) +
							(256 - EWMA_GAIN) * {32'd0, ewma}) >> 8;
						ewma = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
					end
					span = 64'd256000000 / fps;
					guard = ({32'd0, ewma} * SAFETY_GAIN) >> 16;
					admit_at = clamp_time({16'd0, ev.now} + ((guard > span) ? guard : span));
					n_delivered = n_delivered + 1;
				end
			end
		end
		r.delivered = n_delivered;
		r.skipped = n_skipped;
		r.starved = n_starved;
		r.smoothed = ewma[31:8];
		r.admit = admit_at;
		return r;
	endfunction

	function automatic cam_event_t camera_event(logic a, logic [TIME_W-1:0] n,
		logic [DOWN_W-1:0] d, logic l);
		cam_event_t ev;
		ev.act = a;
		ev.now = n;
		ev.down = d;
		ev.listen = l;
		return ev;
	endfunction

	// frame read, mostly at or after the admission time
	function automatic cam_event_t random_frame();
		logic [63:0] at;
		logic [DOWN_W-1:0] d;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 5)
			at = {16'd0, (admit_at > t_now) ? admit_at : t_now} + $urandom_range(0, 3000);
		else if (pick <= 8)
			at = {16'd0, t_now} + $urandom_range(0, 40000);
		else
			at = {16'd0, t_now};
		t_now = clamp_time(at);
		pick = $urandom_range(0, 9);
		if (pick <= 1)
			d = '0;
		else if (pick <= 6)
			d = $urandom_range(1, 60000);
		else if (pick <= 8)
			d = $urandom_range(60000, 400000);
		else
			d = $urandom_range(0, 24'hFFFFFF);
		return camera_event(ACT_FRAME, t_now, d, $urandom_range(0, 7) != 0);
	endfunction

	function automatic cam_event_t random_nobuf();
		t_now = clamp_time({16'd0, t_now} + $urandom_range(0, 5000));
		return camera_event(ACT_NOBUF, t_now, $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 1));
	endfunction

	// any field value, time may jump back or far ahead
	function automatic cam_event_t random_noise();
		logic [31:0] hi;
		logic [31:0] lo;
		hi = $urandom_range(0, 65535);
		lo = $urandom;
		return camera_event($urandom_range(0, 1), {hi[15:0], lo},
			$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1));
	endfunction

	// send one word, predict its result, then maybe idle between bursts
	task automatic send_camera_event(input cam_event_t ev);
		int gap;
		in_valid <= 1'b1;
		valid_on = 1'b1;
		action <= ev.act;
		now_us <= ev.now;
		downstream_max_us <= ev.down;
		has_listeners <= ev.listen;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		results_due.push_back(judge_event(ev));
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				in_valid <= 1'b0;
				valid_on = 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		if (valid_on) begin
			in_valid <= 1'b0;
			valid_on = 1'b0;
		end
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// rewrite all registers once the block is idle
	task automatic apply_rates(input logic [RATE_W-1:0] capture, input logic [RATE_W-1:0] limit,
		input logic cfg_on, input logic sw_on);
		wait_drained();
		write_reg(REG_CAPTURE_RATE, capture);
		write_reg(REG_INFER_LIMIT, limit);
		write_reg(REG_INFER_CFG, {15'd0, cfg_on});
		write_reg(REG_INFER_SW, {15'd0, sw_on});
		cfg_we <= 1'b0;
		cap_rate = capture;
		rate_cap = limit;
		inf_cfg = cfg_on;
		inf_sw = sw_on;
	endtask

	task automatic test_basic_admission();
		apply_rates(16'd7680, 16'd0, 1'b1, 1'b1);
		send_camera_event(camera_event(ACT_FRAME, 48'd0, 24'd0, 1'b1));
		send_camera_event(camera_event(ACT_FRAME, 48'd100, 24'hFFFFFF, 1'b1));
		t_now = admit_at;
		send_camera_event(camera_event(ACT_FRAME, t_now, 24'hFFFFFF, 1'b1));
		t_now = admit_at;
		send_camera_event(camera_event(ACT_FRAME, t_now, 24'd0, 1'b0));
	endtask

	// heavy load: every failed read backs off
	task automatic test_starved_reads();
		send_camera_event(camera_event(ACT_NOBUF, t_now, 24'd0, 1'b0));
		t_now = t_now + 10;
		send_camera_event(camera_event(ACT_NOBUF, t_now, 24'hFFFFFF, 1'b1));
		t_now = admit_at;
		send_camera_event(camera_event(ACT_FRAME, t_now, 24'd1, 1'b1));
	endtask

	task automatic test_inference_gating();
		apply_rates(16'd7680, 16'd0, 1'b1, 1'b0);
		t_now = admit_at;
		send_camera_event(camera_event(ACT_FRAME, t_now, 24'd5, 1'b1));
		apply_rates(16'd7680, 16'd0, 1'b0, 1'b1);
		t_now = admit_at;
		send_camera_event(camera_event(ACT_FRAME, t_now, 24'd5, 1'b1));
	endtask

	// zero capture rate, light load needs three failures, capped backoff
	task automatic test_zero_rate();
		apply_rates(16'd0, 16'd0, 1'b1, 1'b1);
		repeat (3) begin
			t_now = t_now + 1000;
			send_camera_event(camera_event(ACT_NOBUF, t_now, 24'd0, 1'b1));
		end
		t_now = admit_at;
		send_camera_event(camera_event(ACT_FRAME, t_now, 24'd9, 1'b1));
	endtask

	// rate chosen so load ratio sits between 1.3 and 2
	task automatic test_middle_load();
		logic [63:0] rate;
		rate = (ewma == 0) ? 64'd65535 : (64'd16 * LOAD_UNIT / 64'd10) / {32'd0, ewma};
		if (rate == 0)
			rate = 64'd1;
		if (rate > 64'd65535)
			rate = 64'd65535;
		apply_rates(rate[15:0], 16'd0, 1'b1, 1'b1);
		repeat (2) begin
			t_now = t_now + 500;
			send_camera_event(camera_event(ACT_NOBUF, t_now, 24'd0, 1'b0));
		end
	endtask

	// admission time saturates at the top of the time range
	task automatic test_time_ceiling();
		apply_rates(16'd7680, 16'd0, 1'b1, 1'b1);
		send_camera_event(camera_event(ACT_FRAME, MAX_TIME - 5, 24'd7, 1'b1));
		send_camera_event(camera_event(ACT_FRAME, MAX_TIME - 1, 24'd7, 1'b1));
		send_camera_event(camera_event(ACT_FRAME, MAX_TIME, 24'd7, 1'b1));
		// backoff from a small time brings the window back down
		repeat (3) begin
			t_now = t_now + 100;
			send_camera_event(camera_event(ACT_NOBUF, t_now, 24'd0, 1'b0));
		end
		t_now = admit_at;
	endtask

	// streak saturation and backoff step limit
	task automatic test_long_starvation();
		apply_rates(16'd1, 16'd0, 1'b1, 1'b1);
		repeat (260)
			send_camera_event(random_nobuf());
		t_now = admit_at;
		send_camera_event(camera_event(ACT_FRAME, t_now, 24'd300, 1'b1));
	endtask

	task automatic mixed_traffic(input int n_items);
		int sent;
		int pick;
		int len;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = $urandom_range(1, 6);
				repeat (len)
					send_camera_event(random_frame());
			end else if (pick < 85) begin
				len = $urandom_range(1, 7);
				repeat (len)
					send_camera_event(random_nobuf());
			end else if (pick < 97) begin
				len = 1;
				send_camera_event(random_noise());
			end else begin
				// hold off until every result is back
				len = 0;
				wait_drained();
			end
			sent += len;
		end
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
			0: apply_rates(16'd7680, 16'd0, 1'b1, 1'b1);
			1: apply_rates(16'd65535, 16'd65535, 1'b1, 1'b0);
			2: apply_rates(16'd65535, 16'd1, 1'b0, 1'b1);
			3: apply_rates(16'd3840, 16'd7680, 1'b1, 1'b1);
			4: apply_rates(16'd15360, 16'd2560, 1'b0, 1'b0);
			5: apply_rates(16'd1, 16'd0, 1'b1, 1'b1);
			6: apply_rates(16'd65535, 16'd0, 1'b1, 1'b1);
			default: apply_rates($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 1), $urandom_range(0, 1));
			endcase
			mixed_traffic(62);
		end
	endtask

	// receiver: ready pattern changes each time the 6-bit age counter wraps
	always @(posedge clk) begin
		if (ready_age == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_pat <= $urandom;
		end else begin
			ready_pat <= {ready_pat[0], ready_pat[15:1]};
		end
		ready_age <= ready_age + 1;
		case (ready_mode)
		2'd0: out_ready <= 1'b1;
		2'd1: out_ready <= $urandom_range(0, 1);
		2'd2: out_ready <= ($urandom_range(0, 3) == 0);
		default: out_ready <= ready_pat[0];
		endcase
	end

	task automatic compare_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endtask

	// compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		admit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("unexpected result word: verdict %0d", verdict);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				compare_field("verdict", want.verdict, verdict);
				compare_field("frame_number", want.number, frame_number);
				compare_field("delivered_count", want.delivered, delivered_count);
				compare_field("skipped_count", want.skipped, skipped_count);
				compare_field("starved_count", want.starved, starved_count);
				compare_field("smoothed_proc_us", want.smoothed, smoothed_proc_us);
				compare_field("admit_after_us", want.admit, admit_after_us);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// test sequence
	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_admission();
		test_starved_reads();
		test_inference_gating();
		test_zero_rate();
		test_middle_load();
		test_time_ceiling();
		test_long_starvation();
		test_random_traffic();
		wait_drained();
		// catch any stray word after the last one
		repeat (64)
			@(posedge clk);
		if (fail_count == 0 && results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
